// ===== src/u8gl_pkg.sv =====
// Shared definitions for the UTF-8 glyph lookup block: command and status codes,
// lead-byte masks and default sizes. No dependencies.
package u8gl_pkg;

    // Input commands.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_TEXT  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_FOUND    = 2'd0;
    localparam logic [1:0] STATUS_MISSING  = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEAD = 2'd2;

    // Configuration register indexes.
    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_GLYPH_SIZE  = 1'b1;

    // UTF-8 lead-byte classification.
    localparam logic [7:0] HIGH_BIT        = 8'h80;
    localparam logic [7:0] LEAD_MASK_TWO   = 8'hE0;
    localparam logic [7:0] LEAD_TWO        = 8'hC0;
    localparam logic [7:0] LEAD_MASK_THREE = 8'hF0;
    localparam logic [7:0] LEAD_THREE      = 8'hE0;

    // Sizes and reset values.
    localparam int         DEF_TABLE_DEPTH   = 1024;
    localparam int         BOUND_W           = 17;
    localparam logic [7:0] GLYPH_SIZE_RESET  = 8'd16;
    localparam logic [15:0] CURSOR_MAX       = 16'hFFFF;

endpackage

// ===== src/utf8_glyph_lookup.sv =====
// Top level of the UTF-8 glyph lookup: byte gathering, a binary search over the
// key table memory, cursor tracking and an APB-style configuration port.
// Depends on u8gl_pkg.
//
// Sequence: a load, start or partial byte is taken in the idle state alone. A completed character
// is accepted, then each table probe issues the address and then compares the registered read data,
// an empty range after a miss ends the search, and the result is handed to the output register,
// which waits while a full output register is held by a stalled m_ready.
// Flow: one beat at a time; the next beat is accepted in the cycle after the result is handed on.
// Reset (aresetn, synchronous, active low) clears sequencer, cursor, gatherer and registers.
module utf8_glyph_lookup
    import u8gl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input beats
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_text_byte,
    input  logic [9:0]  s_entry_slot,
    input  logic [23:0] s_entry_key,
    // Result beats
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [9:0]  m_glyph_slot,
    output logic [23:0] m_char_key,
    output logic [15:0] m_x_position
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_EMIT
    } state_t;

    // Key table, written by load commands and read one probe at a time.
    logic [23:0] key_table [TABLE_DEPTH];
    logic [23:0] rd_data_reg;

    state_t      state_reg, state_next;
    logic [10:0] entry_count_reg, entry_count_next;
    logic [7:0]  glyph_size_reg, glyph_size_next;
    logic [15:0] cursor_reg, cursor_next;
    logic [15:0] partial_key_reg, partial_key_next;
    logic [1:0]  bytes_needed_reg, bytes_needed_next;
    logic [1:0]  bytes_held_reg, bytes_held_next;
    logic [23:0] key_reg, key_next;
    logic        len3_reg, len3_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [9:0]  res_slot_reg, res_slot_next;
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic [9:0]  m_glyph_slot_reg, m_glyph_slot_next;
    logic [23:0] m_char_key_reg, m_char_key_next;
    logic [15:0] m_x_position_reg, m_x_position_next;

    logic          s_fire;
    logic          cfg_write;
    logic          cfg_index;
    logic [AW+9:0] slot_wide;
    logic [AW-1:0] load_addr;
    logic          load_in_range;
    logic          load_we;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid_full;
    logic [AW+9:0] mid_wide;
    logic [BOUND_W-1:0] count_wide;
    logic [BOUND_W-1:0] search_len;
    logic [7:0]    step;
    logic [16:0]   cursor_sum;
    logic [15:0]   cursor_adv;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[2];

    // Register readback.
    always_comb begin
        case (cfg_index)
            REG_ENTRY_COUNT: prdata = {21'd0, entry_count_reg};
            REG_GLYPH_SIZE:  prdata = {24'd0, glyph_size_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // Load address and range check; slots past the table are dropped.
    assign slot_wide     = {{AW{1'b0}}, s_entry_slot};
    assign load_addr     = slot_wide[AW-1:0];
    assign load_in_range = (BOUND_W'(s_entry_slot) < BOUND_W'(TABLE_DEPTH));
    assign load_we       = s_fire && (s_command == CMD_LOAD) && load_in_range;

    // Probe midpoint of the half-open range [lo, hi).
    assign mid_sum  = (CW+1)'(lo_reg) + (CW+1)'(hi_reg) - (CW+1)'(1);
    assign mid_full = mid_sum[CW:1];
    assign mid_wide = {10'd0, mid_reg};

    // Number of entries searched is capped at the table depth.
    assign count_wide = BOUND_W'(entry_count_reg);
    assign search_len = (count_wide < BOUND_W'(TABLE_DEPTH)) ? count_wide
                                                              : BOUND_W'(TABLE_DEPTH);

    // Cursor advance: full glyph for 3-byte characters, half otherwise, saturating.
    assign step       = len3_reg ? glyph_size_reg : {1'b0, glyph_size_reg[7:1]};
    assign cursor_sum = {1'b0, cursor_reg} + 17'(step);
    assign cursor_adv = cursor_sum[16] ? CURSOR_MAX : cursor_sum[15:0];

    // Table write and registered probe read.
    always_ff @(posedge aclk) begin
        if (load_we) begin
            key_table[load_addr] <= s_entry_key;
        end
        rd_data_reg <= key_table[mid_next];
    end

    // Sequencer next-state logic.
    always_comb begin
        state_next        = state_reg;
        entry_count_next  = entry_count_reg;
        glyph_size_next   = glyph_size_reg;
        cursor_next       = cursor_reg;
        partial_key_next  = partial_key_reg;
        bytes_needed_next = bytes_needed_reg;
        bytes_held_next   = bytes_held_reg;
        key_next          = key_reg;
        len3_next         = len3_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        mid_next          = mid_reg;
        res_status_next   = res_status_reg;
        res_slot_next     = res_slot_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_glyph_slot_next = m_glyph_slot_reg;
        m_char_key_next   = m_char_key_reg;
        m_x_position_next = m_x_position_reg;

        // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
        if (cfg_write) begin
            case (cfg_index)
                REG_ENTRY_COUNT: entry_count_next = pwdata[10:0];
                REG_GLYPH_SIZE:  glyph_size_next  = pwdata[7:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    case (s_command)
                        CMD_START: begin
                            cursor_next       = 16'd0;
                            partial_key_next  = 16'd0;
                            bytes_needed_next = 2'd0;
                            bytes_held_next   = 2'd0;
                        end
                        CMD_TEXT: begin
                            if (bytes_needed_reg == 2'd0) begin
                                if ((s_text_byte & HIGH_BIT) == 8'd0) begin
                                    // Plain ASCII character.
                                    key_next   = {16'd0, s_text_byte};
                                    len3_next  = 1'b0;
                                    lo_next    = '0;
                                    hi_next    = search_len[CW-1:0];
                                    state_next = S_PROBE;
                                end else if ((s_text_byte & LEAD_MASK_TWO) == LEAD_TWO) begin
                                    partial_key_next  = {8'd0, s_text_byte};
                                    bytes_held_next   = 2'd1;
                                    bytes_needed_next = 2'd2;
                                end else if ((s_text_byte & LEAD_MASK_THREE) == LEAD_THREE)
                                begin
                                    partial_key_next  = {8'd0, s_text_byte};
                                    bytes_held_next   = 2'd1;
                                    bytes_needed_next = 2'd3;
                                end else begin
                                    // Unsupported lead byte: report it, cursor stays.
                                    key_next        = {16'd0, s_text_byte};
                                    res_status_next = STATUS_BAD_LEAD;
                                    res_slot_next   = 10'd0;
                                    state_next      = S_EMIT;
                                end
                            end else if (bytes_held_reg == 2'd1) begin
                                partial_key_next = {s_text_byte, partial_key_reg[7:0]};
                                bytes_held_next  = 2'd2;
                                if (bytes_needed_reg == 2'd2) begin
                                    key_next          = {8'd0, s_text_byte,
                                                         partial_key_reg[7:0]};
                                    len3_next         = 1'b0;
                                    lo_next           = '0;
                                    hi_next           = search_len[CW-1:0];
                                    partial_key_next  = 16'd0;
                                    bytes_needed_next = 2'd0;
                                    bytes_held_next   = 2'd0;
                                    state_next        = S_PROBE;
                                end
                            end else begin
                                // Third byte completes a wide character.
                                key_next          = {s_text_byte, partial_key_reg};
                                len3_next         = 1'b1;
                                lo_next           = '0;
                                hi_next           = search_len[CW-1:0];
                                partial_key_next  = 16'd0;
                                bytes_needed_next = 2'd0;
                                bytes_held_next   = 2'd0;
                                state_next        = S_PROBE;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Issue the next table read, or end the search when the range is empty.
            S_PROBE: begin
                if (lo_reg < hi_reg) begin
                    mid_next   = mid_full[AW-1:0];
                    state_next = S_CMP;
                end else begin
                    res_status_next = STATUS_MISSING;
                    res_slot_next   = 10'd0;
                    state_next      = S_EMIT;
                end
            end

            // Compare the probed entry with the key and narrow the range.
            S_CMP: begin
                if (rd_data_reg < key_reg) begin
                    lo_next    = CW'(mid_reg) + CW'(1);
                    state_next = S_PROBE;
                end else if (rd_data_reg > key_reg) begin
                    hi_next    = CW'(mid_reg);
                    state_next = S_PROBE;
                end else begin
                    res_status_next = STATUS_FOUND;
                    res_slot_next   = mid_wide[9:0];
                    state_next      = S_EMIT;
                end
            end

            // Hand the result to the output register once it is free.
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_status_next     = res_status_reg;
                    m_glyph_slot_next = res_slot_reg;
                    m_char_key_next   = key_reg;
                    m_x_position_next = cursor_reg;
                    if (res_status_reg != STATUS_BAD_LEAD) begin
                        cursor_next = cursor_adv;
                    end
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            entry_count_reg  <= 11'd0;
            glyph_size_reg   <= GLYPH_SIZE_RESET;
            cursor_reg       <= 16'd0;
            partial_key_reg  <= 16'd0;
            bytes_needed_reg <= 2'd0;
            bytes_held_reg   <= 2'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            entry_count_reg  <= entry_count_next;
            glyph_size_reg   <= glyph_size_next;
            cursor_reg       <= cursor_next;
            partial_key_reg  <= partial_key_next;
            bytes_needed_reg <= bytes_needed_next;
            bytes_held_reg   <= bytes_held_next;
            m_valid_reg      <= m_valid_next;
        end
        key_reg          <= key_next;
        len3_reg         <= len3_next;
        lo_reg           <= lo_next;
        hi_reg           <= hi_next;
        mid_reg          <= mid_next;
        res_status_reg   <= res_status_next;
        res_slot_reg     <= res_slot_next;
        m_status_reg     <= m_status_next;
        m_glyph_slot_reg <= m_glyph_slot_next;
        m_char_key_reg   <= m_char_key_next;
        m_x_position_reg <= m_x_position_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_glyph_slot = m_glyph_slot_reg;
    assign m_char_key   = m_char_key_reg;
    assign m_x_position = m_x_position_reg;

endmodule
